// ===== rtl/tmae_pkg.sv =====
`default_nettype none
package tmae_pkg;

    localparam int DEFAULT_MAX_DIM = 64;

    localparam logic [1:0] REQ_WRITE_A = 2'd0;
    localparam logic [1:0] REQ_WRITE_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [1:0] MODE_MAX_PLUS  = 2'd0;
    localparam logic [1:0] MODE_MIN_PLUS  = 2'd1;
    localparam logic [1:0] MODE_MAX_TIMES = 2'd2;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_ROWS  = 2'd1;
    localparam logic [1:0] CFG_DEPTH = 2'd2;
    localparam logic [1:0] CFG_COLS  = 2'd3;

    localparam logic [31:0] FLT_MAX_POS  = 32'h7F7F_FFFF;
    localparam logic [31:0] FLT_MAX_NEG  = 32'hFF7F_FFFF;
    localparam logic [31:0] FLT_ZERO     = 32'h0000_0000;
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  row_index;
        logic [5:0]  col_index;
        logic [31:0] entry_bits;
    } req_t;

    typedef struct packed {
        logic [31:0] best_bits;
        logic [5:0]  winner_index;
        logic        status;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/tmae_fpu.sv =====
`default_nettype none
// Three-stage single-precision adder / multiplier, round to nearest even.
module tmae_fpu
    import tmae_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        op_mul,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             out_valid,
    output logic [31:0]      out_bits,
    output logic             busy
);

    // Stage 1 registers.
    logic               s1_v_reg;
    logic               s1_sp_reg;
    logic [31:0]        s1_sp_bits_reg;
    logic               s1_sign_reg;
    logic signed [10:0] s1_x_reg;
    logic [47:0]        s1_mag_reg;

    // Stage 2 registers.
    logic               s2_v_reg;
    logic               s2_sp_reg;
    logic [31:0]        s2_sp_bits_reg;
    logic               s2_sign_reg;
    logic               s2_zero_reg;
    logic signed [10:0] s2_e_reg;
    logic [47:0]        s2_n_reg;

    // Stage 3 registers.
    logic               s3_v_reg;
    logic [31:0]        s3_bits_reg;

    logic               s1_sp_next;
    logic [31:0]        s1_sp_bits_next;
    logic               s1_sign_next;
    logic signed [10:0] s1_x_next;
    logic [47:0]        s1_mag_next;

    logic               s2_zero_next;
    logic signed [10:0] s2_e_next;
    logic [47:0]        s2_n_next;

    logic [31:0]        s3_bits_next;

    // Operand decode and stage 1 datapath.
    always_comb
    begin
        logic        sa;
        logic        sb;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic        a_zero;
        logic        b_zero;
        logic        swap;
        logic        big_s;
        logic [7:0]  big_e;
        logic [23:0] big_m;
        logic [7:0]  sml_e;
        logic [23:0] sml_m;
        logic [7:0]  d;
        logic [26:0] sml_ext;
        logic [26:0] sml_shift;
        logic [26:0] lost_mask;
        logic [26:0] big_ext;
        logic [27:0] sum;
        logic        eff_sub;
        logic [47:0] prod;

        sa = a[31];
        sb = b[31];
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);

        // Adder: order operands by magnitude, align the smaller one.
        swap  = (b[30:0] > a[30:0]);
        big_s = swap ? sb : sa;
        big_e = swap ? eb : ea;
        big_m = swap ? mb : ma;
        sml_e = swap ? ea : eb;
        sml_m = swap ? ma : mb;
        d = big_e - sml_e;
        sml_ext = {sml_m, 3'b000};
        big_ext = {big_m, 3'b000};
        lost_mask = 27'd0;
        if (d >= 8'd27)
        begin
            sml_shift = {26'd0, (sml_m != 24'd0)};
        end
        else
        begin
            lost_mask = (27'd1 << d[4:0]) - 27'd1;
            sml_shift = (sml_ext >> d[4:0]) | {26'd0, ((sml_ext & lost_mask) != 27'd0)};
        end
        eff_sub = (sa != sb);
        sum = eff_sub ? ({1'b0, big_ext} - {1'b0, sml_shift})
                      : ({1'b0, big_ext} + {1'b0, sml_shift});

        prod = ma * mb;

        s1_sp_next      = 1'b0;
        s1_sp_bits_next = FLT_ZERO;
        if (a_nan)
        begin
            s1_sp_next      = 1'b1;
            s1_sp_bits_next = a | QUIET_BIT;
        end
        else if (b_nan)
        begin
            s1_sp_next      = 1'b1;
            s1_sp_bits_next = b | QUIET_BIT;
        end
        else if (op_mul)
        begin
            if ((a_inf && b_zero) || (b_inf && a_zero))
            begin
                s1_sp_next      = 1'b1;
                s1_sp_bits_next = QNAN_DEFAULT;
            end
            else if (a_inf || b_inf)
            begin
                s1_sp_next      = 1'b1;
                s1_sp_bits_next = {sa ^ sb, 8'hFF, 23'd0};
            end
        end
        else
        begin
            if (a_inf && b_inf && eff_sub)
            begin
                s1_sp_next      = 1'b1;
                s1_sp_bits_next = QNAN_DEFAULT;
            end
            else if (a_inf)
            begin
                s1_sp_next      = 1'b1;
                s1_sp_bits_next = a;
            end
            else if (b_inf)
            begin
                s1_sp_next      = 1'b1;
                s1_sp_bits_next = b;
            end
        end

        if (op_mul)
        begin
            s1_sign_next = sa ^ sb;
            s1_x_next    = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd300;
            s1_mag_next  = prod;
        end
        else
        begin
            // An exact cancellation gives +0; two zeros of one sign keep it.
            s1_sign_next = (sum == 28'd0) ? (eff_sub ? 1'b0 : sa) : big_s;
            s1_x_next    = $signed({3'b000, big_e}) - 11'sd153;
            s1_mag_next  = {20'd0, sum};
        end
    end

    // Stage 2: leading-one search and normalization.
    always_comb
    begin
        logic [5:0] pos;
        logic [5:0] lz;

        pos = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (s1_mag_reg[i])
            begin
                pos = 6'(i);
            end
        end
        lz = 6'd47 - pos;
        s2_zero_next = (s1_mag_reg == 48'd0);
        s2_n_next    = s1_mag_reg << lz;
        s2_e_next    = s1_x_reg - $signed({5'd0, lz}) + 11'sd174;
    end

    // Stage 3: subnormal shift, rounding and packing.
    always_comb
    begin
        logic [23:0]        sig;
        logic               g;
        logic               st;
        logic [7:0]         ef;
        logic signed [10:0] sh;
        logic [47:0]        shifted;
        logic [47:0]        mask;
        logic               up;

        sig = 24'd0;
        g   = 1'b0;
        st  = 1'b0;
        ef  = 8'd0;
        sh  = 11'sd1 - s2_e_reg;
        shifted = 48'd0;
        mask    = 48'd0;
        if (s2_e_reg >= 11'sd1)
        begin
            sig = s2_n_reg[47:24];
            g   = s2_n_reg[23];
            st  = (s2_n_reg[22:0] != 23'd0);
            ef  = s2_e_reg[7:0];
        end
        else if (sh >= 11'sd48)
        begin
            st = 1'b1;
        end
        else
        begin
            shifted = s2_n_reg >> sh[5:0];
            mask    = (48'd1 << sh[5:0]) - 48'd1;
            sig = shifted[47:24];
            g   = shifted[23];
            st  = (shifted[22:0] != 23'd0) || ((s2_n_reg & mask) != 48'd0);
        end
        up = g & (st | sig[0]);

        if (s2_sp_reg)
        begin
            s3_bits_next = s2_sp_bits_reg;
        end
        else if (s2_zero_reg)
        begin
            s3_bits_next = {s2_sign_reg, 31'd0};
        end
        else if (s2_e_reg >= 11'sd255)
        begin
            s3_bits_next = {s2_sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            s3_bits_next = {s2_sign_reg, ef, sig[22:0]} + {31'd0, up};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sp_reg      <= s1_sp_next;
        s1_sp_bits_reg <= s1_sp_bits_next;
        s1_sign_reg    <= s1_sign_next;
        s1_x_reg       <= s1_x_next;
        s1_mag_reg     <= s1_mag_next;

        s2_sp_reg      <= s1_sp_reg;
        s2_sp_bits_reg <= s1_sp_bits_reg;
        s2_sign_reg    <= s1_sign_reg;
        s2_zero_reg    <= s2_zero_next;
        s2_e_reg       <= s2_e_next;
        s2_n_reg       <= s2_n_next;

        s3_bits_reg    <= s3_bits_next;
    end

    assign out_valid = s3_v_reg;
    assign out_bits  = s3_bits_reg;
    assign busy      = s1_v_reg | s2_v_reg | s3_v_reg;

endmodule
`default_nettype wire

// ===== rtl/tropical_matmul_argmax_engine.sv =====
// Store writes are accepted only while idle and return nothing.
// A compute request answers after one A and one B read per contracted index (depth capped at MAX_DIM),
// a drain of the read register and three-stage arithmetic pipeline, and a load of the result
// register; the next request follows.
// Out-of-range or zero-depth requests skip the reads and answer via DONE; new requests wait for IDLE.
// Reset clears control state and sets the registers to their defaults; store contents are undefined.
`default_nettype none
module tropical_matmul_argmax_engine
    import tmae_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_t       req,
    output logic            res_valid,
    input  wire logic       res_stall,
    output res_t            res,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [6:0] cfg_data
);

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DIM + 1);

    logic [31:0] left_mem  [STORE_DEPTH];
    logic [31:0] right_mem [STORE_DEPTH];
    logic [31:0] left_q;
    logic [31:0] right_q;

    logic [1:0] mode_reg;
    logic [6:0] rows_reg;
    logic [6:0] depth_reg;
    logic [6:0] cols_reg;

    state_t state_reg;
    state_t state_next;

    logic [5:0]       row_reg;
    logic [5:0]       col_reg;
    logic [CNT_W-1:0] k_reg;
    logic             issue_reg;
    logic             rd_v_reg;
    logic [CNT_W-1:0] rd_k_reg;
    logic [CNT_W-1:0] k1_reg;
    logic [CNT_W-1:0] k2_reg;
    logic [CNT_W-1:0] k3_reg;
    logic [31:0]      best_reg;
    logic [CNT_W-1:0] winner_reg;
    logic             status_reg;
    logic             res_valid_reg;
    res_t             res_reg;

    logic             req_fire;
    logic             issue;
    logic             load_res;
    logic             run_drained;
    logic [8:0]       row9;
    logic [8:0]       col9;
    logic             wr_in_range;
    logic             cmp_in_range;
    logic [8:0]       depth9;
    logic [CNT_W-1:0] depth_eff;
    logic [31:0]      start_val;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    left_raddr;
    logic [AW-1:0]    right_raddr;

    logic             fpu_v;
    logic [31:0]      cand;
    logic             fpu_busy;
    logic             repl;

    function automatic logic fp_le(input logic [31:0] x, input logic [31:0] y);
        logic x_nan;
        logic y_nan;
        logic le;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        if (x_nan || y_nan)
            le = 1'b0;
        else if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0))
            le = 1'b1;
        else if (x[31] != y[31])
            le = x[31];
        else if (x[31])
            le = (x[30:0] >= y[30:0]);
        else
            le = (x[30:0] <= y[30:0]);
        return le;
    endfunction

    assign row9 = {3'b000, req.row_index};
    assign col9 = {3'b000, req.col_index};
    assign wr_in_range = (row9 < 9'(MAX_DIM)) && (col9 < 9'(MAX_DIM));
    assign cmp_in_range = wr_in_range && ({1'b0, req.row_index} < rows_reg)
                          && ({1'b0, req.col_index} < cols_reg);
    assign depth9    = {2'b00, depth_reg};
    assign depth_eff = (depth9 > 9'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(depth9);

    always_comb
    begin
        case (mode_reg)
            MODE_MIN_PLUS:  start_val = FLT_MAX_POS;
            MODE_MAX_TIMES: start_val = FLT_ZERO;
            default:        start_val = FLT_MAX_NEG;
        endcase
    end

    assign wr_addr     = AW'(req.row_index) * AW'(MAX_DIM) + AW'(req.col_index);
    assign left_raddr  = AW'(row_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign right_raddr = AW'(k_reg) * AW'(MAX_DIM) + AW'(col_reg);

    assign req_fire    = req_valid && !req_stall;
    assign run_drained = !issue_reg && !rd_v_reg && !fpu_busy;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_COMPUTE))
                begin
                    if (cmp_in_range && (depth_eff != CNT_W'(0)))
                        state_next = ST_RUN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_RUN:
            begin
                if (run_drained)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        req_stall = 1'b1;
        issue     = 1'b0;
        load_res  = 1'b0;
        case (state_reg)
            ST_IDLE: req_stall = 1'b0;
            ST_RUN:  issue     = issue_reg;
            ST_DONE: load_res  = !res_valid_reg || !res_stall;
            default: req_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && wr_in_range && (req.req_type == REQ_WRITE_A))
            left_mem[wr_addr] <= req.entry_bits;
        left_q <= left_mem[left_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && wr_in_range && (req.req_type == REQ_WRITE_B))
            right_mem[wr_addr] <= req.entry_bits;
        right_q <= right_mem[right_raddr];
    end

    tmae_fpu u_fpu (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_v_reg),
        .op_mul    (mode_reg == MODE_MAX_TIMES),
        .a         (left_q),
        .b         (right_q),
        .out_valid (fpu_v),
        .out_bits  (cand),
        .busy      (fpu_busy)
    );

    assign repl = (mode_reg == MODE_MIN_PLUS) ? !fp_le(best_reg, cand)
                                              : !fp_le(cand, best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MAX_PLUS;
            rows_reg      <= 7'd64;
            depth_reg     <= 7'd64;
            cols_reg      <= 7'd64;
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            rd_v_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:  mode_reg  <= cfg_data[1:0];
                    CFG_ROWS:  rows_reg  <= cfg_data;
                    CFG_DEPTH: depth_reg <= cfg_data;
                    CFG_COLS:  cols_reg  <= cfg_data;
                    default:   mode_reg  <= mode_reg;
                endcase
            end
            state_reg <= state_next;
            rd_v_reg  <= issue;
            if (req_fire && (req.req_type == REQ_COMPUTE) && cmp_in_range
                && (depth_eff != CNT_W'(0)))
                issue_reg <= 1'b1;
            else if (issue && (k_reg == depth_eff - CNT_W'(1)))
                issue_reg <= 1'b0;
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg <= k_reg;
        k1_reg   <= rd_k_reg;
        k2_reg   <= k1_reg;
        k3_reg   <= k2_reg;
        if (req_fire && (req.req_type == REQ_COMPUTE))
        begin
            row_reg    <= req.row_index;
            col_reg    <= req.col_index;
            k_reg      <= CNT_W'(0);
            winner_reg <= CNT_W'(0);
            status_reg <= !cmp_in_range;
            best_reg   <= cmp_in_range ? start_val : FLT_ZERO;
        end
        else
        begin
            if (issue)
                k_reg <= k_reg + CNT_W'(1);
            if (fpu_v && repl)
            begin
                best_reg   <= cand;
                winner_reg <= k3_reg;
            end
        end
        if (load_res)
        begin
            res_reg.best_bits    <= best_reg;
            res_reg.winner_index <= 6'(winner_reg);
            res_reg.status       <= status_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire
